/* rtl/vsslp_pkg.sv */
package vsslp_pkg;

    // Configuration register port.
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes.
    localparam t_cfg_idx REG_CUTOFF   = 2'd0;
    localparam t_cfg_idx REG_HARDNESS = 2'd1;
    localparam t_cfg_idx REG_POLES    = 2'd2;
    localparam t_cfg_idx REG_MIX      = 2'd3;

    // Full scale of a register (1.0 in Q16) and reset values.
    localparam t_cfg CFG_FULL       = 17'd65536;
    localparam t_cfg CFG_CUTOFF_RST = 17'd0;
    localparam t_cfg CFG_HARD_RST   = 17'd32768;
    localparam t_cfg CFG_POLES_RST  = 17'd16384;
    localparam t_cfg CFG_MIX_RST    = 17'd65536;

    // Coefficients are unsigned Q30.
    localparam int COEF_W = 31;
    localparam int CF     = 30;

    typedef logic [COEF_W-1:0] t_coef;

    localparam t_coef ONE_Q30 = 31'h4000_0000;
    localparam t_coef EPS_Q30 = 31'd107;

endpackage

/* rtl/variable_slope_stereo_lowpass.sv */
// Variable-slope stereo lowpass. Each accepted word carries one stereo pair
// and produces one filtered pair. The two channels are processed one after the
// other by a single shared coefficient multiplier under a small sequencer. The
// operations of a channel are the offset, the coefficient, up to four one-pole
// updates, up to four crossfades and the dry/wet mix, each a multiply. The slot
// of a disengaged stage (update or crossfade) and a skipped mix are passed over
// without a multiply. The processing time of an item depends on the poles
// setting and on whether the mix setting is at full scale. s_axis_tready is low
// during that time and rises again in the cycle after the result is loaded, so
// a new pair is accepted only once the previous one is finished. A finished
// result waits in the output register while the next pair is accepted. The next
// result stalls only while that register is still held by the receiver.
// Configuration writes are taken at any time through the config port and must
// only be issued while no pair is in flight.
module variable_slope_stereo_lowpass #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int STATE_WIDTH  = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: left_sample, right_sample (from bit 0 up)
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // Output stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: left_out, right_out (from bit 0 up)
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // Configuration write port.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  vsslp_pkg::t_cfg_idx                    i_cfg_index,
    input  vsslp_pkg::t_cfg                        i_cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int STW   = STATE_WIDTH;
    localparam int XFRAC = SW - 1;
    localparam int SFRAC = STW - 2;
    localparam int IO_W  = ((2*SW+7)/8)*8;
    localparam int MW    = (STW > vsslp_pkg::COEF_W) ? STW : vsslp_pkg::COEF_W;
    localparam int DW    = MW + 1;
    localparam int AW    = MW + 2;
    localparam int OUP   = (XFRAC > SFRAC) ? (XFRAC - SFRAC) : 0;
    localparam int OW    = STW + OUP + 1;

    localparam logic signed [AW-1:0] S_MAX = {{(AW-STW+1){1'b0}}, {(STW-1){1'b1}}};
    localparam logic signed [AW-1:0] S_MIN = {{(AW-STW+1){1'b1}}, {(STW-1){1'b0}}};
    localparam logic signed [OW-1:0] O_MAX = {{(OW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [OW-1:0] O_MIN = {{(OW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIFF  = 3'd2;
    localparam logic [2:0] ST_MAG   = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_APPLY = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Operation slots of one channel. Stage slots alternate update and crossfade.
    localparam logic [3:0] OP_OFF = 4'd0;
    localparam logic [3:0] OP_K   = 4'd1;
    localparam logic [3:0] OP_S0  = 4'd2;
    localparam logic [3:0] OP_X3  = 4'd9;
    localparam logic [3:0] OP_MIX = 4'd10;
    localparam logic [3:0] OP_END = 4'd11;

    // Saturate a state-path sum to the state width.
    function automatic logic signed [STW-1:0] sat_state(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] c;
        c = (v > S_MAX) ? S_MAX : ((v < S_MIN) ? S_MIN : v);
        return c[STW-1:0];
    endfunction

    // Saturate a rescaled value to the sample width.
    function automatic logic signed [SW-1:0] sat_out(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] c;
        c = (v > O_MAX) ? O_MAX : ((v < O_MIN) ? O_MIN : v);
        return c[SW-1:0];
    endfunction

    // Configuration registers.
    vsslp_pkg::t_cfg r_cut;
    vsslp_pkg::t_cfg r_hard;
    vsslp_pkg::t_cfg r_pole;
    vsslp_pkg::t_cfg r_mix;
    vsslp_pkg::t_cfg w_cfg_sat;

    // Sequencer and datapath registers.
    logic [2:0]               r_state;
    logic [3:0]               r_op;
    logic                     r_ch;
    logic                     r_bank;
    logic                     r_ovalid;
    logic signed [SW-1:0]     r_in_l;
    logic signed [SW-1:0]     r_in_r;
    logic signed [SW-1:0]     r_left;
    logic [IO_W-1:0]          r_tdata;
    logic signed [STW-1:0]    r_x;
    logic signed [STW-1:0]    r_dry;
    logic signed [STW-1:0]    r_s;
    vsslp_pkg::t_coef         r_absx;
    vsslp_pkg::t_coef         r_off;
    vsslp_pkg::t_coef         r_k;
    logic signed [DW-1:0]     r_diff;
    vsslp_pkg::t_coef         r_coef;
    logic                     r_neg;
    logic signed [STW-1:0]    r_store [16];

    // Derived settings.
    logic signed [18:0]       w_tight2;
    logic [17:0]              w_t2mag;
    logic                     w_tpos;
    logic [17:0]              w_amt16;
    vsslp_pkg::t_cfg          w_amt_c;
    vsslp_pkg::t_coef         w_amount;
    vsslp_pkg::t_coef         w_tmag;
    vsslp_pkg::t_coef         w_wet [4];
    logic [3:0]               w_wet_on;
    vsslp_pkg::t_coef         w_mix;
    logic                     w_mix_full;

    // Channel front end.
    logic signed [SW-1:0]     w_samp;
    logic                     w_samp_neg;
    logic [SW-1:0]            w_samp_mag;
    vsslp_pkg::t_coef         w_absx;
    logic signed [STW-1:0]    w_x_in;

    // Operation decode.
    logic [3:0]               w_op_m2;
    logic [1:0]               w_stage;
    logic                     w_is_stage;
    logic                     w_is_x;
    logic [3:0]               w_idx;
    logic signed [STW-1:0]    w_s_rd;
    logic                     w_op_on;
    logic signed [DW-1:0]     w_diff;
    vsslp_pkg::t_coef         w_coef;
    vsslp_pkg::t_coef         w_off_in;
    logic [MW-1:0]            w_mag;

    // Multiplier result and combine.
    logic                     w_mul_start;
    logic                     w_mul_done;
    logic [MW-1:0]            w_mul_res;
    logic signed [DW-1:0]     w_res_u;
    logic signed [DW-1:0]     w_res_s;
    logic signed [32:0]       w_off_sum;
    vsslp_pkg::t_coef         w_off_c;
    logic signed [STW-1:0]    w_new_s;
    logic signed [STW-1:0]    w_new_x;
    logic signed [STW-1:0]    w_new_m;

    // Output rescale.
    logic signed [OW-1:0]     w_scaled;
    logic signed [SW-1:0]     w_out;
    logic                     w_out_load;

    // Configuration writes, saturated to full scale.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_sat   = (i_cfg_data > vsslp_pkg::CFG_FULL) ? vsslp_pkg::CFG_FULL : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut  <= vsslp_pkg::CFG_CUTOFF_RST;
            r_hard <= vsslp_pkg::CFG_HARD_RST;
            r_pole <= vsslp_pkg::CFG_POLES_RST;
            r_mix  <= vsslp_pkg::CFG_MIX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vsslp_pkg::REG_CUTOFF:   r_cut  <= w_cfg_sat;
                vsslp_pkg::REG_HARDNESS: r_hard <= w_cfg_sat;
                vsslp_pkg::REG_POLES:    r_pole <= w_cfg_sat;
                vsslp_pkg::REG_MIX:      r_mix  <= w_cfg_sat;
                default:                 r_mix  <= r_mix;
            endcase
        end
    end

    // Amount and tightness from cutoff and hardness.
    assign w_tight2 = signed'({1'b0, r_hard, 1'b0}) - 19'sd65536;
    assign w_tpos   = !w_tight2[18] && (w_tight2 != 19'sd0);
    assign w_t2mag  = w_tight2[18] ? 18'(-w_tight2) : w_tight2[17:0];
    assign w_amt16  = 18'(r_cut) + w_t2mag;
    assign w_amt_c  = (w_amt16 > 18'(vsslp_pkg::CFG_FULL)) ? vsslp_pkg::CFG_FULL
                                                           : w_amt16[16:0];
    assign w_amount = (w_amt_c == '0) ? vsslp_pkg::EPS_Q30 : {w_amt_c, 14'b0};
    // A negative tightness is halved, which is one less shift.
    assign w_tmag   = w_tpos ? {w_t2mag[16:0], 14'b0} : {1'b0, w_t2mag[16:0], 13'b0};

    // Progressive stage wets from four times the pole amount.
    always_comb begin
        logic signed [20:0] w;
        for (int i = 0; i < 4; i++) begin
            w = signed'({2'b0, r_pole, 2'b0}) - signed'(21'(i * 65536));
            if (w < 21'sd0) begin
                w = 21'sd0;
            end else if (w > 21'sd65536) begin
                w = 21'sd65536;
            end
            w_wet[i]    = {w[16:0], 14'b0};
            w_wet_on[i] = (w != 21'sd0);
        end
    end

    assign w_mix      = {r_mix, 14'b0};
    assign w_mix_full = (r_mix == vsslp_pkg::CFG_FULL);

    // Current channel sample, its magnitude, and its rescaled forms.
    assign w_samp     = r_ch ? r_in_r : r_in_l;
    assign w_samp_neg = w_samp[SW-1];
    assign w_samp_mag = w_samp_neg ? (~unsigned'(w_samp) + 1'b1) : unsigned'(w_samp);

    generate
        if (XFRAC <= vsslp_pkg::CF) begin : g_absx_up
            assign w_absx = vsslp_pkg::COEF_W'(w_samp_mag) << (vsslp_pkg::CF - XFRAC);
        end else begin : g_absx_dn
            localparam int AD = XFRAC - vsslp_pkg::CF;
            logic [SW:0] w_ar;
            assign w_ar   = {1'b0, w_samp_mag} + ((SW+1)'(1) << (AD - 1));
            assign w_absx = vsslp_pkg::COEF_W'(w_ar >> AD);
        end

        if (SFRAC >= XFRAC) begin : g_x_up
            assign w_x_in = STW'(w_samp) <<< (SFRAC - XFRAC);
        end else begin : g_x_dn
            localparam int XD = XFRAC - SFRAC;
            logic [SW:0] w_xr;
            logic [SW:0] w_xm;
            assign w_xr   = {1'b0, w_samp_mag} + ((SW+1)'(1) << (XD - 1));
            assign w_xm   = w_xr >> XD;
            assign w_x_in = w_samp_neg ? -signed'(STW'(w_xm)) : signed'(STW'(w_xm));
        end

        if (XFRAC >= SFRAC) begin : g_out_up
            assign w_scaled = OW'(r_x) <<< OUP;
        end else begin : g_out_dn
            localparam int OD = SFRAC - XFRAC;
            logic [STW-1:0] w_om;
            logic [STW:0]   w_or;
            logic [STW:0]   w_os;
            assign w_om     = r_x[STW-1] ? (~unsigned'(r_x) + 1'b1) : unsigned'(r_x);
            assign w_or     = {1'b0, w_om} + ((STW+1)'(1) << (OD - 1));
            assign w_os     = w_or >> OD;
            assign w_scaled = r_x[STW-1] ? -signed'(OW'(w_os)) : signed'(OW'(w_os));
        end
    endgenerate

    assign w_out = sat_out(w_scaled);

    // The output word is loaded when the right channel is done and the register is free.
    assign w_out_load = (r_state == ST_OUT) && r_ch && (!r_ovalid || m_axis_tready);

    // Operation decode: stage number, update or crossfade, accumulator address.
    assign w_op_m2    = r_op - OP_S0;
    assign w_stage    = w_op_m2[2:1];
    assign w_is_x     = w_op_m2[0];
    assign w_is_stage = (r_op >= OP_S0) && (r_op <= OP_X3);
    assign w_idx      = {r_ch, w_stage, ~r_bank};
    assign w_s_rd     = r_store[w_idx];
    assign w_off_in   = w_tpos ? r_absx : (vsslp_pkg::ONE_Q30 - r_absx);

    // Multiplier operand and coefficient for the current operation.
    always_comb begin
        w_op_on = 1'b1;
        w_diff  = DW'(signed'({1'b0, w_off_in}));
        w_coef  = w_tmag;
        if (r_op == OP_K) begin
            w_diff = DW'(signed'({1'b0, r_off}));
            w_coef = w_amount;
        end else if (w_is_stage) begin
            w_op_on = w_wet_on[w_stage];
            if (w_is_x) begin
                w_diff = DW'(r_s) - DW'(r_x);
                w_coef = w_wet[w_stage];
            end else begin
                w_diff = DW'(r_x) - DW'(w_s_rd);
                w_coef = r_k;
            end
        end else if (r_op == OP_MIX) begin
            w_op_on = !w_mix_full;
            w_diff  = DW'(r_x) - DW'(r_dry);
            w_coef  = w_mix;
        end
    end

    assign w_mag       = r_diff[DW-1] ? MW'(-r_diff) : MW'(r_diff);
    assign w_mul_start = (r_state == ST_MAG);

    vsslp_mulq #(
        .MAG_W (MW)
    ) u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_mag   (w_mag),
        .i_coef  (r_coef),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    // Signed product and the combine step of each operation.
    assign w_res_u = signed'(DW'(w_mul_res));
    assign w_res_s = r_neg ? -w_res_u : w_res_u;

    assign w_off_sum = w_tpos
        ? signed'(33'(vsslp_pkg::ONE_Q30)) - signed'(33'(w_tmag))
          + signed'(33'(w_mul_res[vsslp_pkg::COEF_W-1:0]))
        : signed'(33'(vsslp_pkg::ONE_Q30)) - signed'(33'(w_tmag))
          - signed'(33'(w_mul_res[vsslp_pkg::COEF_W-1:0]));

    always_comb begin
        if (w_off_sum < signed'(33'(vsslp_pkg::EPS_Q30))) begin
            w_off_c = vsslp_pkg::EPS_Q30;
        end else if (w_off_sum > signed'(33'(vsslp_pkg::ONE_Q30))) begin
            w_off_c = vsslp_pkg::ONE_Q30;
        end else begin
            w_off_c = w_off_sum[vsslp_pkg::COEF_W-1:0];
        end
    end

    assign w_new_s = sat_state(AW'(r_s) + AW'(w_res_s));
    assign w_new_x = sat_state(AW'(r_x) + AW'(w_res_s));
    assign w_new_m = sat_state(AW'(r_dry) + AW'(w_res_s));

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_OFF;
            r_ch     <= 1'b0;
            r_bank   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ch    <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_op    <= OP_OFF;
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    if (r_op == OP_END) begin
                        r_state <= ST_OUT;
                    end else if (w_op_on) begin
                        r_state <= ST_MAG;
                    end else begin
                        r_op <= r_op + 4'd1;
                    end
                end
                ST_MAG: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (w_mul_done) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    r_op    <= r_op + 4'd1;
                    r_state <= ST_DIFF;
                end
                ST_OUT: begin
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= ST_LOAD;
                    end else if (!r_ovalid || m_axis_tready) begin
                        r_bank   <= ~r_bank;
                        r_ch     <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_in_l <= s_axis_tdata[SW-1:0];
            r_in_r <= s_axis_tdata[2*SW-1:SW];
        end
        if (r_state == ST_LOAD) begin
            r_x    <= w_x_in;
            r_dry  <= w_x_in;
            r_absx <= w_absx;
        end
        if (r_state == ST_DIFF && r_op != OP_END && w_op_on) begin
            r_diff <= w_diff;
            r_coef <= w_coef;
            if (w_is_stage && !w_is_x) begin
                r_s <= w_s_rd;
            end
        end
        if (r_state == ST_MAG) begin
            r_neg <= r_diff[DW-1];
        end
        if (r_state == ST_APPLY) begin
            if (r_op == OP_OFF) begin
                r_off <= w_off_c;
            end else if (r_op == OP_K) begin
                r_k <= w_mul_res[vsslp_pkg::COEF_W-1:0];
            end else if (w_is_stage && !w_is_x) begin
                r_s <= w_new_s;
            end else if (w_is_stage) begin
                r_x <= w_new_x;
            end else begin
                r_x <= w_new_m;
            end
        end
        if (r_state == ST_OUT) begin
            if (!r_ch) begin
                r_left <= w_out;
            end else if (!r_ovalid || m_axis_tready) begin
                r_tdata <= IO_W'({w_out, r_left});
            end
        end
    end

    // Stage accumulators: both banks of both channels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_store[i] <= '0;
            end
        end else if (r_state == ST_APPLY && w_is_stage && !w_is_x) begin
            r_store[w_idx] <= w_new_s;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_tdata;

endmodule

/* rtl/vsslp_mulq.sv */
// Coefficient multiplier: res = round(mag * coef / 2^30), half away from zero
// on the magnitude. One narrow multiplier handles the low half of the magnitude
// and then the high half in successive steps; the result is registered in the
// rounding step and is flagged by a one-cycle done pulse.
module vsslp_mulq #(
    parameter int MAG_W = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [MAG_W-1:0]           i_mag,
    input  vsslp_pkg::t_coef           i_coef,
    output logic                       o_done,
    output logic [MAG_W-1:0]           o_res
);

    localparam int LO_W  = (MAG_W + 1) / 2;
    localparam int PW    = LO_W + vsslp_pkg::COEF_W;
    localparam int ACC_W = MAG_W + vsslp_pkg::COEF_W + 1;

    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_LO   = 2'd1;
    localparam logic [1:0] STEP_HI   = 2'd2;
    localparam logic [1:0] STEP_RND  = 2'd3;

    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (vsslp_pkg::CF - 1);

    logic [1:0]             r_step;
    logic                   r_done;
    logic [MAG_W-1:0]       r_mag;
    vsslp_pkg::t_coef       r_coef;
    logic [ACC_W-1:0]       r_acc;
    logic [PW-1:0]          r_prod;
    logic [MAG_W-1:0]       r_res;

    logic [LO_W-1:0]        w_opnd;
    logic [PW-1:0]          w_prod;
    logic [ACC_W-1:0]       w_sum;

    // The shared multiplier sees the low half first, then the high half.
    assign w_opnd = (r_step == STEP_LO) ? r_mag[LO_W-1:0] : LO_W'(r_mag[MAG_W-1:LO_W]);
    assign w_prod = PW'(w_opnd) * PW'(r_coef);

    // Recombine the partial products and round at the Q30 point.
    assign w_sum = r_acc + (ACC_W'(r_prod) << LO_W) + HALF;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_step)
                STEP_IDLE: begin
                    if (i_start) begin
                        r_step <= STEP_LO;
                    end
                end
                STEP_LO:  r_step <= STEP_HI;
                STEP_HI:  r_step <= STEP_RND;
                STEP_RND: begin
                    r_step <= STEP_IDLE;
                    r_done <= 1'b1;
                end
                default:  r_step <= STEP_IDLE;
            endcase
        end
    end

    // Operand and partial product registers.
    always_ff @(posedge i_clk) begin
        if (r_step == STEP_IDLE && i_start) begin
            r_mag  <= i_mag;
            r_coef <= i_coef;
        end
        if (r_step == STEP_LO) begin
            r_acc <= ACC_W'(w_prod);
        end
        if (r_step == STEP_HI) begin
            r_prod <= w_prod;
        end
        if (r_step == STEP_RND) begin
            r_res <= w_sum[vsslp_pkg::CF +: MAG_W];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
